### hdl/bounded_fifo_with_search_unit_defines.svh
// ----------------------------------------------------------------------------
// bounded_fifo_with_search_unit_defines
// Assertion macros shared by the queue RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_FIFO_WITH_SEARCH_UNIT_DEFINES_SVH
`define BOUNDED_FIFO_WITH_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset.
`define BFSU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BFSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define BFSU_ASSERT(lbl, clk, rstn, prop)
`define BFSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hdl/bfifo_pkg.sv
// ----------------------------------------------------------------------------
// bfifo_pkg
// Shared types and constants for the bounded FIFO with search.
// ----------------------------------------------------------------------------
package bfifo_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 2;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_DEQUEUE = 2'd1,
        MODE_SEARCH  = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_ENQ,
        DP_DEQ,
        DP_CLEAR,
        DP_RD_HEAD,
        DP_SCAN
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    fin;        // load result register this cycle
        t_status status;
        logic    take_data;  // result data from the memory read register
        logic    found;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  empty;
        logic  full;
        logic  match;        // read data equals the search key
        logic  last;         // read data is the newest entry
    } t_dp_stat;

endpackage

### hdl/bounded_fifo_with_search_unit.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_search_unit
// Each transaction is loaded in S_IDLE; enqueue, clear and ops on an empty
// queue finish in S_EXEC; a dequeue reads the head there and pops it in S_DEQ;
// a search scans from the head, one memory read per cycle, up to a match or
// the newest entry. A new transaction is taken in the cycle o_valid is high;
// results cannot be stalled. Synchronous active-low reset empties the queue.
// ----------------------------------------------------------------------------
module bounded_fifo_with_search_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command side: transaction accepted when start && !busy
    input  logic                                start,
    output logic                                busy,
    input  logic [bfifo_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [bfifo_pkg::DATA_W-1:0] i_data_in,
    // result side: one-cycle strobe, always accepted
    output logic                                o_valid,
    output logic signed [bfifo_pkg::DATA_W-1:0] o_data_out,
    output logic [bfifo_pkg::ST_W-1:0]          o_status,
    output logic                                o_found,
    output logic [bfifo_pkg::OCC_W-1:0]         o_occupancy
);
    import bfifo_pkg::*;

    // Controller/datapath split: FSM issues one datapath op per cycle,
    // datapath reports mode, empty/full and search compare results.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bfifo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Entry memory is a single-port-read, single-write array; the search
    // walks it head to newest, comparing one registered read per cycle.
    bfifo_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_mode),
        .i_data_in   (i_data_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_valid     (o_valid),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_occupancy (o_occupancy)
    );

endmodule

### hdl/bfifo_dp.sv
// ----------------------------------------------------------------------------
// bfifo_dp
// Datapath: entry memory, head/tail pointers, count, scan cursor, result reg.
// ----------------------------------------------------------------------------
`include "bounded_fifo_with_search_unit_defines.svh"

module bfifo_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [bfifo_pkg::MODE_W-1:0]            i_mode,
    input  logic signed [bfifo_pkg::DATA_W-1:0]     i_data_in,
    input  bfifo_pkg::t_dp_cmd                      i_cmd,
    output bfifo_pkg::t_dp_stat                     o_stat,
    output logic                                    o_valid,
    output logic signed [bfifo_pkg::DATA_W-1:0]     o_data_out,
    output logic [bfifo_pkg::ST_W-1:0]              o_status,
    output logic                                    o_found,
    output logic [bfifo_pkg::OCC_W-1:0]             o_occupancy
);
    import bfifo_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_W-1:0] r_mem [CAPACITY];

    t_mode             r_mode;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_rd_data;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_k, n_k;
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     rd_addr;

    logic              r_valid;
    logic [DATA_W-1:0] r_dout;
    t_status           r_status;
    logic              r_found;
    logic [OCC_W-1:0]  r_occ;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        return (idx == AW'(CAPACITY - 1)) ? '0 : AW'(idx + AW'(1));
    endfunction

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_idx   = r_idx;
        n_k     = r_k;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        rd_addr = r_head;
        unique case (i_cmd.op)
            DP_NONE, DP_LOAD: begin
            end
            DP_ENQ: begin
                wr_en   = 1'b1;
                n_tail  = next_idx(r_tail);
                n_count = CW'(r_count + CW'(1));
            end
            DP_DEQ: begin
                n_count = CW'(r_count - CW'(1));
                if (r_count == CW'(1)) begin
                    // queue drains: both pointers return to slot zero
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    n_head = next_idx(r_head);
                end
            end
            DP_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            DP_RD_HEAD: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_idx   = next_idx(r_head);
                n_k     = '0;
            end
            DP_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_idx   = next_idx(r_idx);
                n_k     = CW'(r_k + CW'(1));
            end
            default: begin
            end
        endcase
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= r_key;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_valid <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_k   <= n_k;
        if (i_cmd.op == DP_LOAD) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_data_in;
        end
        if (i_cmd.fin) begin
            r_dout   <= i_cmd.take_data ? r_rd_data : '0;
            r_status <= i_cmd.status;
            r_found  <= i_cmd.found;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_stat.mode  = r_mode;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(CAPACITY));
    assign o_stat.match = (r_rd_data == r_key);
    assign o_stat.last  = (r_k == CW'(r_count - CW'(1)));

    assign o_valid     = r_valid;
    assign o_data_out  = r_dout;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_occupancy = r_occ;

    `BFSU_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `BFSU_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count != '0) || (r_head == '0 && r_tail == '0))

endmodule

### hdl/bfifo_ctrl.sv
// ----------------------------------------------------------------------------
// bfifo_ctrl
// Controller FSM: sequences each transaction through the datapath.
// ----------------------------------------------------------------------------
`include "bounded_fifo_with_search_unit_defines.svh"

module bfifo_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bfifo_pkg::t_dp_stat  i_stat,
    output bfifo_pkg::t_dp_cmd   o_cmd
);
    import bfifo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DEQ  = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state  r_state, n_state;
    t_dp_cmd cmd;

    always_comb begin
        n_state       = r_state;
        cmd.op        = DP_NONE;
        cmd.fin       = 1'b0;
        cmd.status    = ST_OK;
        cmd.take_data = 1'b0;
        cmd.found     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.op  = DP_LOAD;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.mode)
                    MODE_ENQUEUE: begin
                        cmd.fin = 1'b1;
                        n_state = S_IDLE;
                        if (i_stat.full) begin
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.op = DP_ENQ;
                        end
                    end
                    MODE_DEQUEUE: begin
                        if (i_stat.empty) begin
                            cmd.fin    = 1'b1;
                            cmd.status = ST_EMPTY;
                            n_state    = S_IDLE;
                        end else begin
                            cmd.op  = DP_RD_HEAD;
                            n_state = S_DEQ;
                        end
                    end
                    MODE_SEARCH: begin
                        if (i_stat.empty) begin
                            cmd.fin    = 1'b1;
                            cmd.status = ST_EMPTY;
                            n_state    = S_IDLE;
                        end else begin
                            cmd.op  = DP_RD_HEAD;
                            n_state = S_SCAN;
                        end
                    end
                    MODE_CLEAR: begin
                        cmd.op  = DP_CLEAR;
                        cmd.fin = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DEQ: begin
                cmd.op        = DP_DEQ;
                cmd.fin       = 1'b1;
                cmd.take_data = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                priority if (i_stat.match) begin
                    cmd.fin   = 1'b1;
                    cmd.found = 1'b1;
                    n_state   = S_IDLE;
                end else if (i_stat.last) begin
                    cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cmd.op = DP_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = cmd;

    `BFSU_ASSERT_NEXT(a_fin_to_idle, i_clk, i_rst_n, cmd.fin, r_state == S_IDLE)
    `BFSU_ASSERT(a_scan_nonempty, i_clk, i_rst_n, (r_state != S_SCAN) || !i_stat.empty)

endmodule

### bench/bounded_fifo_with_search_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_fifo_with_search_unit_tb
// Self-checking bench for the bounded FIFO with search. A shadow queue
// predicts every result at the edge a command transaction is accepted. A
// monitor compares each o_valid strobe field by field against the oldest
// prediction. Stimulus is a short directed list followed by random phases:
// fill, drain, search-heavy and mixed. The phases push the queue through
// full, empty, drain and index wrap. The sender idles in random bursts.
// ----------------------------------------------------------------------------
module bounded_fifo_with_search_unit_tb;
    import bfifo_pkg::*;

    localparam int QDEPTH       = 16;     // DUT default CAPACITY
    localparam int RANDOM_ITEMS = 1930;
    localparam int IDLE_LIMIT   = 2000;   // worst item: a full gap plus a full-queue search
    localparam int TAIL_CYCLES  = 40;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_mode                     mode;
        logic signed [DATA_W-1:0]  word;
    } t_fifo_cmd;

    typedef struct {
        logic signed [DATA_W-1:0]  data_out;
        t_status                   status;
        logic                      found;
        logic [OCC_W-1:0]          occupancy;
    } t_fifo_result;

    // stimulus phases; each biases the mix of operations
    typedef enum int {PH_FILL, PH_DRAIN, PH_SEARCH, PH_MIXED} t_phase;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic [MODE_W-1:0]         i_mode      = MODE_ENQUEUE;
    logic signed [DATA_W-1:0]  i_data_in   = '0;
    logic                      o_valid;
    logic signed [DATA_W-1:0]  o_data_out;
    logic [ST_W-1:0]           o_status;
    logic                      o_found;
    logic [OCC_W-1:0]          o_occupancy;

    bounded_fifo_with_search_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_data_in   (i_data_in),
        .o_valid     (o_valid),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_occupancy (o_occupancy)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow queue: state of the FIFO as the bench believes it to be.
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0]  shadow_words [QDEPTH];
    int unsigned               shadow_head  = 0;
    int unsigned               shadow_tail  = 0;
    int unsigned               shadow_count = 0;

    t_fifo_cmd                 pending_cmds [$];     // not yet offered to the DUT
    t_fifo_result              expected_results [$]; // predicted, not yet seen
    logic signed [DATA_W-1:0]  recent_words [$];     // recent enqueues, for search keys

    int                        error_count    = 0;
    int                        accepted_count = 0;
    int                        total_items    = 0;

    // Apply one operation to the shadow queue and return what the DUT should report.
    function automatic t_fifo_result queue_predict(t_mode mode, logic signed [DATA_W-1:0] word);
        t_fifo_result r;
        int unsigned  idx;
        r.data_out = '0;
        r.status   = ST_OK;
        r.found    = 1'b0;
        case (mode)
            MODE_ENQUEUE: begin
                if (shadow_count < QDEPTH) begin
                    shadow_words[shadow_tail] = word;
                    shadow_tail  = (shadow_tail + 1) % QDEPTH;
                    shadow_count = shadow_count + 1;
                end else begin
                    r.status = ST_FULL;          // word dropped, state untouched
                end
            end
            MODE_DEQUEUE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out   = shadow_words[shadow_head];
                    shadow_head  = (shadow_head + 1) % QDEPTH;
                    shadow_count = shadow_count - 1;
                    if (shadow_count == 0) begin
                        // drained: pointers snap back to slot 0
                        shadow_head = 0;
                        shadow_tail = 0;
                    end
                end
            end
            MODE_SEARCH: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // scan oldest to newest, newest entry included
                    for (int k = 0; k < shadow_count; k++) begin
                        idx = (shadow_head + k) % QDEPTH;
                        if (shadow_words[idx] == word)
                            r.found = 1'b1;
                    end
                end
            end
            default: begin
                shadow_head  = 0;
                shadow_tail  = 0;
                shadow_count = 0;
            end
        endcase
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_cmd(t_mode mode, logic signed [DATA_W-1:0] word);
        t_fifo_cmd c;
        c.mode = mode;
        c.word = word;
        pending_cmds.push_back(c);
        if (mode == MODE_ENQUEUE) begin
            recent_words.push_back(word);
            if (recent_words.size() > 24)
                void'(recent_words.pop_front());
        end
    endtask

    // Mostly full-range words; small values give duplicates, extremes hit the edges.
    function automatic logic signed [DATA_W-1:0] pick_word();
        logic signed [DATA_W-1:0] w;
        int unsigned              v;
        v = $urandom_range(0, 99);
        if (v < 55) begin
            w = $urandom;
        end else if (v < 80) begin
            w = $urandom_range(0, 15);
            w = w - 8;
        end else begin
            case ($urandom_range(0, 3))
                0:       w = WORD_MIN;
                1:       w = WORD_MAX;
                2:       w = '0;
                default: w = -1;
            endcase
        end
        return w;
    endfunction

    // Search keys: usually something enqueued lately, so hits are common.
    function automatic logic signed [DATA_W-1:0] pick_key();
        if (recent_words.size() > 0 && $urandom_range(0, 99) < 65)
            return recent_words[$urandom_range(0, recent_words.size() - 1)];
        return pick_word();
    endfunction

    function automatic t_mode pick_mode(t_phase ph);
        int unsigned v;
        v = $urandom_range(0, 99);
        if (v < 2)
            return MODE_CLEAR;
        case (ph)
            PH_FILL:   return (v < 80) ? MODE_ENQUEUE : (v < 88) ? MODE_DEQUEUE : MODE_SEARCH;
            PH_DRAIN:  return (v < 70) ? MODE_DEQUEUE : (v < 80) ? MODE_ENQUEUE : MODE_SEARCH;
            PH_SEARCH: return (v < 60) ? MODE_SEARCH  : (v < 82) ? MODE_ENQUEUE : MODE_DEQUEUE;
            default:   return (v < 35) ? MODE_ENQUEUE : (v < 68) ? MODE_DEQUEUE : MODE_SEARCH;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        t_phase ph;
        int     phase_len;
        t_mode  m;

        // directed: empty-queue ops, extreme words, search hits at head,
        // middle and newest, a miss, drain, clear
        add_cmd(MODE_DEQUEUE, 32'sd0);          // dequeue when empty
        add_cmd(MODE_SEARCH,  32'sd0);          // search when empty
        add_cmd(MODE_ENQUEUE, WORD_MAX);
        add_cmd(MODE_ENQUEUE, WORD_MIN);
        add_cmd(MODE_ENQUEUE, 32'sd0);
        add_cmd(MODE_ENQUEUE, -32'sd1);
        add_cmd(MODE_SEARCH,  WORD_MIN);
        add_cmd(MODE_SEARCH,  -32'sd1);         // newest entry
        add_cmd(MODE_SEARCH,  WORD_MAX);        // oldest entry
        add_cmd(MODE_SEARCH,  32'sd12345);      // miss
        add_cmd(MODE_DEQUEUE, 32'sd0);
        add_cmd(MODE_DEQUEUE, 32'sd0);
        add_cmd(MODE_CLEAR,   32'sd0);
        add_cmd(MODE_SEARCH,  32'sd0);          // stale word must not match
        add_cmd(MODE_DEQUEUE, 32'sd0);
        add_cmd(MODE_ENQUEUE, 32'sh5A5A_5A5A);
        add_cmd(MODE_ENQUEUE, 32'shA5A5_A5A5);
        add_cmd(MODE_DEQUEUE, 32'sd0);
        add_cmd(MODE_DEQUEUE, 32'sd0);          // drains, pointers reset
        add_cmd(MODE_ENQUEUE, 32'sd7);
        add_cmd(MODE_SEARCH,  32'sd7);
        add_cmd(MODE_CLEAR,   32'sd0);

        // random phases; fill phases bias toward full, drain phases toward empty
        while (pending_cmds.size() < 22 + RANDOM_ITEMS) begin
            ph        = t_phase'($urandom_range(0, 3));
            phase_len = $urandom_range(10, 60);
            repeat (phase_len) begin
                m = pick_mode(ph);
                case (m)
                    MODE_ENQUEUE: add_cmd(m, pick_word());
                    MODE_SEARCH:  add_cmd(m, pick_key());
                    default:      add_cmd(m, pick_word());   // data ignored
                endcase
            end
        end
        total_items = pending_cmds.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: predicts on acceptance, then offers the next command unless a
    // gap is running. start stays high across back-to-back transactions.
    // ------------------------------------------------------------------------
    t_fifo_cmd cur_cmd;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge i_clk) begin : drive_proc
        t_fifo_cmd nxt;
        logic      took;
        took = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(queue_predict(cur_cmd.mode, cur_cmd.word));
                accepted_count = accepted_count + 1;
                took = 1'b1;
            end
            if (!start || took) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    nxt     = pending_cmds.pop_front();
                    cur_cmd = nxt;
                    start     <= 1'b1;
                    i_mode    <= nxt.mode;
                    i_data_in <= nxt.word;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        // new burst; about a third get no idle gap after this first command
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobe must match the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor_proc
        t_fifo_result exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no transaction outstanding", $time);
                error_count = error_count + 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_data_out !== exp_r.data_out) begin
                    $display("%0t: data_out expected %0d actual %0d",
                             $time, exp_r.data_out, o_data_out);
                    error_count = error_count + 1;
                end
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                    error_count = error_count + 1;
                end
                if (o_found !== exp_r.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, exp_r.found, o_found);
                    error_count = error_count + 1;
                end
                if (o_occupancy !== exp_r.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, exp_r.occupancy, o_occupancy);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with neither a command nor a result accepted.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
